/* src/atna_pkg.sv */
package atna_pkg;

  // Store geometry and field widths.
  localparam int ALARM_SLOTS = 8;
  localparam int SLOT_W      = 3;
  localparam int COUNT_W     = 4;
  localparam int HOUR_W      = 5;
  localparam int MIN_W       = 6;
  localparam int TYPE_W      = 2;
  localparam int ENTRY_W     = HOUR_W + MIN_W + TYPE_W;

  // Time arithmetic.
  localparam int NOW_W         = 12;
  localparam int AT_W          = 11;
  localparam int DIST_W        = 13;
  localparam int NO_ALARM_DIST = 1441;
  localparam int DAY_MINUTES   = 1440;
  localparam int HOUR_MINUTES  = 60;
  localparam int BCD_TEN       = 10;

  localparam logic [TYPE_W-1:0] TYPE_DAILY = 2'd1;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_EDIT  = 2'd1,
    KIND_DEL   = 2'd2,
    KIND_QUERY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [TYPE_W-1:0] atype;
  } entry_t;

endpackage

/* src/atna_ram.sv */
module atna_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/alarm_table_next_alarm_top.sv */
// Alarm store with a soonest-alarm query.
//
// Commands arrive as input transactions on in_valid_i / in_ready_o: add,
// edit, delete and query. Each command produces exactly one result
// transaction on out_valid_o / out_ready_i, carrying the accept flag, the
// query outcome and the entry count after the command.
// The entries live in a small RAM with one write and one registered read
// port; one command is worked on at a time.
// Add, edit and every rejected command go from acceptance straight to the
// result state, which loads the output register. A delete moves the later
// entries down through the RAM, one per cycle, and then lowers the entry
// count; a query reads every stored entry once and keeps the soonest one.
// Once the result state has loaded the output register, the block returns
// to idle and takes the next command.
// A finished result waits in the output register; if the receiver stalls,
// the next command is still accepted and worked on, and its result is held
// back until the output register has been emptied.
// Reset empties the store (entry count zero) and the output register.
module alarm_table_next_alarm_top
  import atna_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [SLOT_W-1:0]  slot_index_i,
  input  logic [HOUR_W-1:0]  alarm_hour_i,
  input  logic [MIN_W-1:0]   alarm_minute_i,
  input  logic [TYPE_W-1:0]  alarm_type_i,
  input  logic [5:0]         now_hour_bcd_i,
  input  logic [6:0]         now_minute_bcd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o,
  output logic               found_o,
  output logic [SLOT_W-1:0]  next_slot_o,
  output logic [HOUR_W-1:0]  next_hour_o,
  output logic [MIN_W-1:0]   next_minute_o,
  output logic [TYPE_W-1:0]  next_type_o,
  output logic [COUNT_W-1:0] entry_count_o
);

  state_e state_q, state_d;

  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] ptr_q, ptr_d;
  logic               rd_pend_q, rd_pend_d;
  logic [SLOT_W-1:0]  wa_q, wa_d;
  logic [NOW_W-1:0]   now_q, now_d;
  logic signed [DIST_W-1:0] best_q, best_d;

  logic               res_acc_q, res_acc_d;
  logic               res_found_q, res_found_d;
  logic [SLOT_W-1:0]  res_slot_q, res_slot_d;
  entry_t             res_entry_q, res_entry_d;

  logic               out_valid_q, out_valid_d;
  logic               out_acc_q, out_acc_d;
  logic               out_found_q, out_found_d;
  logic [SLOT_W-1:0]  out_slot_q, out_slot_d;
  entry_t             out_entry_q, out_entry_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [SLOT_W-1:0]  ram_raddr;
  entry_t             ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  logic               in_acc;
  logic               idx_ok;
  logic               full;
  logic               more;
  logic               out_free;
  logic [5:0]         now_hour;
  logic [6:0]         now_min;
  logic [AT_W-1:0]    at_min;
  logic signed [DIST_W-1:0] diff_raw;
  logic signed [DIST_W-1:0] diff;
  logic               eligible;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign idx_ok     = {1'b0, slot_index_i} < count_q;
  assign full       = count_q >= COUNT_W'(ALARM_SLOTS);
  assign more       = ptr_q < count_q;
  assign out_free   = ~out_valid_q | out_ready_i;

  // Current time: raw nibbles weighted as BCD digits, then minutes since midnight.
  assign now_hour = 6'(now_hour_bcd_i[5:4]) * 6'(BCD_TEN) + 6'(now_hour_bcd_i[3:0]);
  assign now_min  = 7'(now_minute_bcd_i[6:4]) * 7'(BCD_TEN) + 7'(now_minute_bcd_i[3:0]);

  // Distance of the entry read back from the RAM; only daily alarms wrap.
  assign ram_rdata = entry_t'(ram_rdata_raw);
  assign at_min    = AT_W'(ram_rdata.hour) * AT_W'(HOUR_MINUTES) + AT_W'(ram_rdata.minute);
  assign diff_raw  = $signed({2'b00, at_min}) - $signed({1'b0, now_q});
  always_comb begin
    diff     = diff_raw;
    eligible = 1'b1;
    if (diff_raw < 0) begin
      if (ram_rdata.atype == TYPE_DAILY) begin
        diff = diff_raw + DIST_W'(DAY_MINUTES);
      end else begin
        eligible = 1'b0;
      end
    end
  end

  atna_ram #(
    .Width (ENTRY_W),
    .Depth (ALARM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (kind_e'(kind_i))
            KIND_DEL:   state_d = idx_ok ? ST_SHIFT : ST_RESP;
            KIND_QUERY: state_d = ST_SCAN;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_SHIFT, ST_SCAN: begin
        if (!more && !rd_pend_q) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, RAM accesses and result registers.
  always_comb begin
    count_d     = count_q;
    ptr_d       = ptr_q;
    rd_pend_d   = rd_pend_q;
    wa_d        = wa_q;
    now_d       = now_q;
    best_d      = best_q;
    res_acc_d   = res_acc_q;
    res_found_d = res_found_q;
    res_slot_d  = res_slot_q;
    res_entry_d = res_entry_q;
    out_valid_d = out_valid_q;
    out_acc_d   = out_acc_q;
    out_found_d = out_found_q;
    out_slot_d  = out_slot_q;
    out_entry_d = out_entry_q;
    out_count_d = out_count_q;
    ram_we      = 1'b0;
    ram_waddr   = wa_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q[SLOT_W-1:0];

    // The output register empties when its transaction is taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_acc_d   = 1'b0;
          res_found_d = 1'b0;
          res_slot_d  = '0;
          res_entry_d = '0;
          rd_pend_d   = 1'b0;
          case (kind_e'(kind_i))
            KIND_ADD: begin
              if (!full) begin
                ram_we    = 1'b1;
                ram_waddr = count_q[SLOT_W-1:0];
                ram_wdata = '{hour: alarm_hour_i, minute: alarm_minute_i,
                              atype: alarm_type_i};
                count_d   = count_q + COUNT_W'(1);
                res_acc_d = 1'b1;
              end
            end
            KIND_EDIT: begin
              if (idx_ok) begin
                ram_we    = 1'b1;
                ram_waddr = slot_index_i;
                ram_wdata = '{hour: alarm_hour_i, minute: alarm_minute_i,
                              atype: alarm_type_i};
                res_acc_d = 1'b1;
              end
            end
            KIND_DEL: begin
              if (idx_ok) begin
                res_acc_d = 1'b1;
                ptr_d     = {1'b0, slot_index_i} + COUNT_W'(1);
              end
            end
            KIND_QUERY: begin
              res_acc_d = 1'b1;
              now_d     = NOW_W'(now_hour) * NOW_W'(HOUR_MINUTES) + NOW_W'(now_min);
              best_d    = DIST_W'(NO_ALARM_DIST);
              ptr_d     = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT: begin
        // Write back the entry read last cycle one place lower.
        if (rd_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wa_q;
          ram_wdata = ram_rdata;
        end
        if (more) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[SLOT_W-1:0];
          wa_d      = SLOT_W'(ptr_q - COUNT_W'(1));
          ptr_d     = ptr_q + COUNT_W'(1);
          rd_pend_d = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
          if (!rd_pend_q) begin
            count_d = count_q - COUNT_W'(1);
          end
        end
      end
      ST_SCAN: begin
        // Compare the entry read last cycle; strictly smaller wins, so the lowest index keeps ties.
        if (rd_pend_q && eligible && (diff < best_q)) begin
          best_d      = diff;
          res_found_d = 1'b1;
          res_slot_d  = wa_q;
          res_entry_d = ram_rdata;
        end
        if (more) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[SLOT_W-1:0];
          wa_d      = ptr_q[SLOT_W-1:0];
          ptr_d     = ptr_q + COUNT_W'(1);
          rd_pend_d = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_acc_d   = res_acc_q;
          out_found_d = res_found_q;
          out_slot_d  = res_slot_q;
          out_entry_d = res_entry_q;
          out_count_d = count_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    wa_q        <= wa_d;
    now_q       <= now_d;
    best_q      <= best_d;
    res_acc_q   <= res_acc_d;
    res_found_q <= res_found_d;
    res_slot_q  <= res_slot_d;
    res_entry_q <= res_entry_d;
    out_acc_q   <= out_acc_d;
    out_found_q <= out_found_d;
    out_slot_q  <= out_slot_d;
    out_entry_q <= out_entry_d;
    out_count_q <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = out_acc_q;
  assign found_o       = out_found_q;
  assign next_slot_o   = out_slot_q;
  assign next_hour_o   = out_entry_q.hour;
  assign next_minute_o = out_entry_q.minute;
  assign next_type_o   = out_entry_q.atype;
  assign entry_count_o = out_count_q;

endmodule
